// ----- design/tspc_pkg.sv -----
// shared types and constants for the traffic signal phase controller
package tspc_pkg;

  // operating modes
  localparam logic [1:0] MODE_CYCLIC = 2'd0;
  localparam logic [1:0] MODE_STOP   = 2'd1;
  localparam logic [1:0] MODE_TJUNC  = 2'd2;

  // configuration register indexes
  localparam logic [2:0] CFG_MODE        = 3'd0;
  localparam logic [2:0] CFG_TJUNC_NS    = 3'd1;
  localparam logic [2:0] CFG_GREEN_MS    = 3'd2;
  localparam logic [2:0] CFG_YELLOW_MS   = 3'd3;
  localparam logic [2:0] CFG_ALL_RED_MS  = 3'd4;
  localparam logic [2:0] CFG_START_PHASE = 3'd5;

  // cyclic phases
  localparam logic [2:0] PH_NS_GREEN  = 3'd0;
  localparam logic [2:0] PH_NS_YELLOW = 3'd1;
  localparam logic [2:0] PH_RED_A     = 3'd2;
  localparam logic [2:0] PH_EW_GREEN  = 3'd3;
  localparam logic [2:0] PH_EW_YELLOW = 3'd4;
  localparam logic [2:0] PH_RED_B     = 3'd5;

  // reported phase codes outside cyclic mode
  localparam logic [3:0] PHASE_STOP     = 4'd6;
  localparam logic [3:0] PHASE_TJUNC_NS = 4'd7;
  localparam logic [3:0] PHASE_TJUNC_EW = 4'd8;

  localparam logic [19:0] GREEN_MS_RST   = 20'd30000;
  localparam logic [19:0] YELLOW_MS_RST  = 20'd3000;
  localparam logic [19:0] ALL_RED_MS_RST = 20'd2000;

  localparam int NUM_DIRS    = 4;
  localparam int SHOWN_SLOTS = 4;
  localparam int KEEP_BITS   = 4;

  typedef logic [15:0] car_id_t;
  typedef logic [19:0] ms_t;

  typedef struct packed {
    logic [3:0]                      phase;
    ms_t                             countdown_ms;
    logic [2:0]                      queue_count;
    logic [SHOWN_SLOTS-1:0][15:0]    queue_car;
  } result_t;

  function automatic logic [2:0] next_phase(input logic [2:0] ph);
    return (ph == PH_RED_B) ? PH_NS_GREEN : ph + 3'd1;
  endfunction

  function automatic logic [2:0] start_load(input logic [2:0] sp);
    return (sp > PH_RED_B) ? PH_NS_GREEN : sp;
  endfunction

  function automatic ms_t phase_dur(input logic [2:0] ph, input ms_t green,
                                    input ms_t yellow, input ms_t all_red);
    ms_t d;
    case (ph)
      PH_NS_GREEN, PH_EW_GREEN:   d = green;
      PH_NS_YELLOW, PH_EW_YELLOW: d = yellow;
      default:                    d = all_red;
    endcase
    return d;
  endfunction

endpackage

// ----- design/traffic_signal_phase_controller_unit.sv -----
// traffic signal phase controller: cyclic phases, four-way stop queue, fixed t-junction phase
// the result word for an accepted tick is registered in the output register, or in the skid register under out_stall
// throughput: one tick word per cycle while in_stall is low, state update is a single combinational pass
// under out_stall the skid register takes one more word, then in_stall rises until a pop
// reset: start phase 0 with the green duration loaded, queue empty, registers at defaults
// any configuration write to a defined index (0 to 5) reloads the start phase and its duration and empties the queue
module traffic_signal_phase_controller_unit
  import tspc_pkg::*;
#(
  parameter int QUEUE_SLOTS = 4
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [19:0] cfg_data,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_tick_ms,
  input  logic [3:0]  in_arrival_mask,
  input  logic [15:0] in_front_car_east,
  input  logic [15:0] in_front_car_west,
  input  logic [15:0] in_front_car_north,
  input  logic [15:0] in_front_car_south,
  input  logic [3:0]  in_keep_mask,

  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_phase,
  output logic [19:0] out_countdown_ms,
  output logic [2:0]  out_queue_count,
  output logic [15:0] out_queue_car_0,
  output logic [15:0] out_queue_car_1,
  output logic [15:0] out_queue_car_2,
  output logic [15:0] out_queue_car_3
);

  localparam int FW = $clog2(QUEUE_SLOTS + 1);

  // configuration
  logic [1:0] mode_r, mode_nxt;
  logic       tjunc_ns_r, tjunc_ns_nxt;
  ms_t        green_r, green_nxt;
  ms_t        yellow_r, yellow_nxt;
  ms_t        all_red_r, all_red_nxt;
  logic [2:0] start_r, start_nxt;
  logic       cfg_hit;

  // controller state
  logic [2:0]                       phase_r, phase_nxt;
  ms_t                              countdown_r, countdown_nxt;
  logic [QUEUE_SLOTS-1:0][15:0]     ids_r, ids_nxt;
  logic [FW-1:0]                    fill_r, fill_nxt;

  // output side
  result_t    out_r, out_nxt, skid_r, skid_nxt, res;
  logic       out_valid_r, out_valid_nxt, skid_valid_r, skid_valid_nxt;
  logic       accept, pop;

  // queue update work
  logic [QUEUE_SLOTS-1:0]           keep_slot;
  logic [QUEUE_SLOTS-1:0][FW-1:0]   dest;
  logic [QUEUE_SLOTS-1:0][15:0]     kept;
  logic [FW-1:0]                    n;
  logic [NUM_DIRS-1:0][15:0]        front;
  logic                             dup;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !in_stall;
  assign pop       = out_valid_r && !out_stall;
  assign in_stall  = skid_valid_r;

  assign front = {in_front_car_south, in_front_car_north, in_front_car_west, in_front_car_east};

  always_comb begin
    mode_nxt     = mode_r;
    tjunc_ns_nxt = tjunc_ns_r;
    green_nxt    = green_r;
    yellow_nxt   = yellow_r;
    all_red_nxt  = all_red_r;
    start_nxt    = start_r;
    cfg_hit      = 1'b0;
    if (cfg_valid && cfg_ready) begin
      cfg_hit = 1'b1;
      case (cfg_index)
        CFG_MODE:        mode_nxt     = cfg_data[1:0];
        CFG_TJUNC_NS:    tjunc_ns_nxt = cfg_data[0];
        CFG_GREEN_MS:    green_nxt    = cfg_data;
        CFG_YELLOW_MS:   yellow_nxt   = cfg_data;
        CFG_ALL_RED_MS:  all_red_nxt  = cfg_data;
        CFG_START_PHASE: start_nxt    = cfg_data[2:0];
        default:         cfg_hit      = 1'b0;
      endcase
    end
  end

  // stop queue: compact kept slots in order, then append arrivals E, W, N, S not already queued while slots remain
  always_comb begin
    for (int i = 0; i < QUEUE_SLOTS; i++) begin
      if (i < KEEP_BITS) begin
        keep_slot[i] = (FW'(i) < fill_r) && in_keep_mask[2'(i)];
      end else begin
        keep_slot[i] = FW'(i) < fill_r;
      end
    end
    dest[0] = '0;
    for (int i = 1; i < QUEUE_SLOTS; i++) begin
      dest[i] = dest[i-1] + FW'(keep_slot[i-1]);
    end
    n = dest[QUEUE_SLOTS-1] + FW'(keep_slot[QUEUE_SLOTS-1]);
    kept = '0;
    for (int k = 0; k < QUEUE_SLOTS; k++) begin
      for (int i = k; i < QUEUE_SLOTS; i++) begin
        if (keep_slot[i] && dest[i] == FW'(k)) begin
          kept[k] = ids_r[i];
        end
      end
    end
    for (int d = 0; d < NUM_DIRS; d++) begin
      dup = 1'b0;
      for (int i = 0; i < QUEUE_SLOTS; i++) begin
        if (FW'(i) < n && kept[i] == front[d]) begin
          dup = 1'b1;
        end
      end
      if (in_arrival_mask[d] && !dup && n < FW'(QUEUE_SLOTS)) begin
        for (int k = 0; k < QUEUE_SLOTS; k++) begin
          if (FW'(k) == n) begin
            kept[k] = front[d];
          end
        end
        n = n + FW'(1);
      end
    end
  end

  always_comb begin
    phase_nxt     = phase_r;
    countdown_nxt = countdown_r;
    ids_nxt       = ids_r;
    fill_nxt      = fill_r;
    res.countdown_ms = '0;
    if (mode_r == MODE_TJUNC) begin
      res.phase = tjunc_ns_r ? PHASE_TJUNC_NS : PHASE_TJUNC_EW;
    end else if (mode_r == MODE_STOP) begin
      res.phase = PHASE_STOP;
      ids_nxt   = kept;
      fill_nxt  = n;
    end else begin
      if ({4'd0, in_tick_ms} >= countdown_r) begin
        phase_nxt     = next_phase(phase_r);
        countdown_nxt = phase_dur(phase_nxt, green_r, yellow_r, all_red_r);
      end else begin
        countdown_nxt = countdown_r - {4'd0, in_tick_ms};
      end
      res.phase        = {1'b0, phase_nxt};
      res.countdown_ms = countdown_nxt;
    end
    res.queue_count = (fill_nxt > FW'(7)) ? 3'd7 : 3'(fill_nxt);
    for (int k = 0; k < SHOWN_SLOTS; k++) begin
      res.queue_car[k] = (FW'(k) < fill_nxt) ? ids_nxt[k] : 16'd0;
    end
  end

  // output register with one skid word behind it
  always_comb begin
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (!out_valid_r || pop) begin
      if (skid_valid_r) begin
        out_nxt        = skid_r;
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end else begin
        out_nxt       = res;
        out_valid_nxt = accept;
      end
    end else if (accept) begin
      skid_nxt       = res;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_CYCLIC;
      tjunc_ns_r   <= 1'b0;
      green_r      <= GREEN_MS_RST;
      yellow_r     <= YELLOW_MS_RST;
      all_red_r    <= ALL_RED_MS_RST;
      start_r      <= PH_NS_GREEN;
      phase_r      <= PH_NS_GREEN;
      countdown_r  <= GREEN_MS_RST;
      fill_r       <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      mode_r       <= mode_nxt;
      tjunc_ns_r   <= tjunc_ns_nxt;
      green_r      <= green_nxt;
      yellow_r     <= yellow_nxt;
      all_red_r    <= all_red_nxt;
      start_r      <= start_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
      if (cfg_hit) begin
        phase_r     <= start_load(start_nxt);
        countdown_r <= phase_dur(start_load(start_nxt), green_nxt, yellow_nxt, all_red_nxt);
        fill_r      <= '0;
      end else if (accept) begin
        phase_r     <= phase_nxt;
        countdown_r <= countdown_nxt;
        fill_r      <= fill_nxt;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
    if (accept && !cfg_hit) begin
      ids_r <= ids_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_phase        = out_r.phase;
  assign out_countdown_ms = out_r.countdown_ms;
  assign out_queue_count  = out_r.queue_count;
  assign out_queue_car_0  = out_r.queue_car[0];
  assign out_queue_car_1  = out_r.queue_car[1];
  assign out_queue_car_2  = out_r.queue_car[2];
  assign out_queue_car_3  = out_r.queue_car[3];

endmodule

// ----- sim/traffic_signal_phase_controller_unit_tb.sv -----
// testbench for the traffic signal phase controller: predicts and checks every result word
`timescale 1ns / 1ps
module traffic_signal_phase_controller_unit_tb;
  import tspc_pkg::*;

  localparam int CLK_PERIOD     = 8;
  localparam int QUEUE_DEPTH    = 4;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int DRAIN_CYCLES   = 4;
  localparam int RANDOM_BATCHES = 9;
  localparam int BATCH_ITEMS    = 50;
  localparam int POOL_SIZE      = 6;

  // mode 3 is not defined and runs as cyclic
  localparam logic [1:0] MODE_UNDEF = 2'd3;
  // indexes past the register list
  localparam logic [2:0] CFG_SPARE_6 = 3'd6;
  localparam logic [2:0] CFG_SPARE_7 = 3'd7;

  typedef struct packed {
    logic [15:0]                tick_ms;
    logic [3:0]                 arrival;
    logic [NUM_DIRS-1:0][15:0]  front_car;  // 0 east, 1 west, 2 north, 3 south
    logic [3:0]                 keep;
  } tick_word_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [19:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  tick_word_t  drive_word;
  logic        out_valid;
  logic        out_stall;
  logic [3:0]  out_phase;
  logic [19:0] out_countdown_ms;
  logic [2:0]  out_queue_count;
  logic [15:0] out_queue_car_0;
  logic [15:0] out_queue_car_1;
  logic [15:0] out_queue_car_2;
  logic [15:0] out_queue_car_3;

  traffic_signal_phase_controller_unit dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_tick_ms         (drive_word.tick_ms),
    .in_arrival_mask    (drive_word.arrival),
    .in_front_car_east  (drive_word.front_car[0]),
    .in_front_car_west  (drive_word.front_car[1]),
    .in_front_car_north (drive_word.front_car[2]),
    .in_front_car_south (drive_word.front_car[3]),
    .in_keep_mask       (drive_word.keep),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_phase          (out_phase),
    .out_countdown_ms   (out_countdown_ms),
    .out_queue_count    (out_queue_count),
    .out_queue_car_0    (out_queue_car_0),
    .out_queue_car_1    (out_queue_car_1),
    .out_queue_car_2    (out_queue_car_2),
    .out_queue_car_3    (out_queue_car_3)
  );

  // predictor copy of the registers and state
  logic [1:0] ctl_mode;
  logic       ctl_tjunc_ns;
  ms_t        ctl_green;
  ms_t        ctl_yellow;
  ms_t        ctl_all_red;
  logic [2:0] ctl_start;
  logic [2:0] sig_phase;
  ms_t        sig_countdown;
  car_id_t    stop_queue [QUEUE_DEPTH];
  int         stop_fill;

  result_t    expected_words [$];
  int         gap_pct = 0;
  int         hold_pct = 0;
  int         errors = 0;
  int         items_sent = 0;
  int         results_checked = 0;
  int         cfg_writes = 0;
  int         cycle_count = 0;

  function automatic ms_t phase_length(logic [2:0] ph);
    case (ph)
      PH_NS_GREEN, PH_EW_GREEN:   return ctl_green;
      PH_NS_YELLOW, PH_EW_YELLOW: return ctl_yellow;
      default:                    return ctl_all_red;
    endcase
  endfunction

  function automatic void reload_start();
    sig_phase = (ctl_start > PH_RED_B) ? PH_NS_GREEN : ctl_start;
    sig_countdown = phase_length(sig_phase);
    for (int i = 0; i < QUEUE_DEPTH; i++) stop_queue[i] = '0;
    stop_fill = 0;
  endfunction

  function automatic void apply_register(logic [2:0] idx, ms_t data);
    case (idx)
      CFG_MODE:        ctl_mode = data[1:0];
      CFG_TJUNC_NS:    ctl_tjunc_ns = data[0];
      CFG_GREEN_MS:    ctl_green = data;
      CFG_YELLOW_MS:   ctl_yellow = data;
      CFG_ALL_RED_MS:  ctl_all_red = data;
      CFG_START_PHASE: ctl_start = data[2:0];
      default:         return;
    endcase
    reload_start();
  endfunction

  function automatic result_t predict_signal(tick_word_t w);
    result_t r;
    car_id_t kept [QUEUE_DEPTH];
    int      n;
    logic    dup;
    r = '0;
    if (ctl_mode == MODE_TJUNC) begin
      r.phase = ctl_tjunc_ns ? PHASE_TJUNC_NS : PHASE_TJUNC_EW;
    end else if (ctl_mode == MODE_STOP) begin
      n = 0;
      for (int i = 0; i < QUEUE_DEPTH; i++) kept[i] = '0;
      // compact surviving cars, keep bits of empty slots are don't-care
      for (int i = 0; i < stop_fill; i++) begin
        if (w.keep[i]) begin
          kept[n] = stop_queue[i];
          n++;
        end
      end
      for (int d = 0; d < NUM_DIRS; d++) begin
        dup = 1'b0;
        for (int i = 0; i < n; i++) if (kept[i] == w.front_car[d]) dup = 1'b1;
        if (w.arrival[d] && !dup && n < QUEUE_DEPTH) begin
          kept[n] = w.front_car[d];
          n++;
        end
      end
      stop_queue = kept;
      stop_fill = n;
      r.phase = PHASE_STOP;
    end else begin
      // a long tick ends the phase but advances it by one step only
      if (ms_t'(w.tick_ms) >= sig_countdown) begin
        sig_phase = (sig_phase == PH_RED_B) ? PH_NS_GREEN : sig_phase + 3'd1;
        sig_countdown = phase_length(sig_phase);
      end else begin
        sig_countdown = sig_countdown - ms_t'(w.tick_ms);
      end
      r.phase = {1'b0, sig_phase};
      r.countdown_ms = sig_countdown;
    end
    r.queue_count = 3'(stop_fill);
    for (int i = 0; i < SHOWN_SLOTS; i++) r.queue_car[i] = (i < stop_fill) ? stop_queue[i] : '0;
    return r;
  endfunction

  function automatic tick_word_t make_tick(logic [15:0] tick, logic [3:0] arrival,
                                           car_id_t e, car_id_t w, car_id_t n, car_id_t s,
                                           logic [3:0] keep);
    tick_word_t t;
    t.tick_ms = tick;
    t.arrival = arrival;
    t.front_car = {s, n, w, e};
    t.keep = keep;
    return t;
  endfunction

  function automatic ms_t pick_duration();
    case ($urandom_range(9))
      0:       return '0;
      1:       return 20'hFFFFF;
      2:       return ms_t'($urandom);
      default: return ms_t'($urandom_range(400, 1));
    endcase
  endfunction

  initial clk = 1'b0;
  always #(CLK_PERIOD / 2) clk = ~clk;

  always @(negedge clk) out_stall <= rst_n && ($urandom_range(99) < hold_pct);

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still expected",
               cycle_count, expected_words.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // predict on every accepted tick word, then check every accepted result word
  always @(posedge clk) begin : check_results
    result_t                    want;
    logic [SHOWN_SLOTS-1:0][15:0] seen_cars;
    if (rst_n && in_valid && !in_stall) expected_words.push_back(predict_signal(drive_word));
    if (rst_n && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        $error("result word with no expectation: phase %0d countdown %0d",
               out_phase, out_countdown_ms);
        errors++;
      end else begin
        want = expected_words.pop_front();
        seen_cars = {out_queue_car_3, out_queue_car_2, out_queue_car_1, out_queue_car_0};
        if (out_phase !== want.phase) begin
          $error("phase mismatch: expected %0d, actual %0d", want.phase, out_phase);
          errors++;
        end
        if (out_countdown_ms !== want.countdown_ms) begin
          $error("countdown_ms mismatch: expected %0d, actual %0d",
                 want.countdown_ms, out_countdown_ms);
          errors++;
        end
        if (out_queue_count !== want.queue_count) begin
          $error("queue_count mismatch: expected %0d, actual %0d",
                 want.queue_count, out_queue_count);
          errors++;
        end
        for (int i = 0; i < SHOWN_SLOTS; i++) begin
          if (seen_cars[i] !== want.queue_car[i]) begin
            $error("queue_car_%0d mismatch: expected 0x%04h, actual 0x%04h",
                   i, want.queue_car[i], seen_cars[i]);
            errors++;
          end
        end
        results_checked++;
      end
    end
  end

  // called at a falling edge, returns at a falling edge with valid low
  task automatic send_tick(tick_word_t w);
    while ($urandom_range(99) < gap_pct) @(negedge clk);
    drive_word = w;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    items_sent++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // registers change only with nothing in flight
  task automatic write_reg(logic [2:0] idx, ms_t data);
    while (expected_words.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_index = idx;
    cfg_data = data;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    apply_register(idx, data);
    cfg_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic test_cyclic_defaults();
    send_tick(make_tick(16'd0, '0, '0, '0, '0, '0, '0));
    send_tick(make_tick(16'd29999, '0, '0, '0, '0, '0, '0));
    send_tick(make_tick(16'd1, '0, '0, '0, '0, '0, '0));
    repeat (3) send_tick(make_tick(16'hFFFF, '1, '1, '1, '1, '1, '1));
  endtask

  task automatic test_duration_extremes();
    write_reg(CFG_GREEN_MS, '0);
    write_reg(CFG_YELLOW_MS, '0);
    write_reg(CFG_ALL_RED_MS, '0);
    // zero length phases last one tick each, wrapping from the last phase
    write_reg(CFG_START_PHASE, ms_t'(PH_RED_B));
    repeat (3) send_tick(make_tick(16'd0, '0, '0, '0, '0, '0, '0));
    write_reg(CFG_START_PHASE, 20'd6);
    send_tick(make_tick(16'd0, '0, '0, '0, '0, '0, '0));
    write_reg(CFG_START_PHASE, 20'd7);
    send_tick(make_tick(16'd0, '0, '0, '0, '0, '0, '0));
    write_reg(CFG_YELLOW_MS, 20'hFFFFF);
    write_reg(CFG_ALL_RED_MS, 20'hFFFFF);
    write_reg(CFG_GREEN_MS, 20'hFFFFF);
    write_reg(CFG_START_PHASE, ms_t'(PH_NS_GREEN));
    repeat (2) send_tick(make_tick(16'hFFFF, '0, '0, '0, '0, '0, '0));
    write_reg(CFG_MODE, ms_t'(MODE_UNDEF));
    send_tick(make_tick(16'hFFFF, '0, '0, '0, '0, '0, '0));
  endtask

  task automatic test_tjunction();
    write_reg(CFG_MODE, ms_t'(MODE_TJUNC));
    write_reg(CFG_TJUNC_NS, 20'd1);
    send_tick(make_tick(16'd500, '0, '0, '0, '0, '0, '0));
    write_reg(CFG_TJUNC_NS, 20'd0);
    send_tick(make_tick(16'hFFFF, '1, '1, '1, '1, '1, '1));
  endtask

  task automatic test_stop_queue();
    write_reg(CFG_MODE, ms_t'(MODE_STOP));
    // south repeats east in the same tick
    send_tick(make_tick(16'd10, 4'b1111, 16'h0000, 16'hFFFF, 16'h1234, 16'h0000, 4'b0000));
    // one slot left: east fits, west is dropped
    send_tick(make_tick(16'd10, 4'b0011, 16'hABCD, 16'h5555, '0, '0, 4'b1111));
    // drop two, east is already queued, north is new
    send_tick(make_tick(16'd10, 4'b0101, 16'hFFFF, '0, 16'h0F0F, '0, 4'b1010));
    send_tick(make_tick(16'd10, 4'b0000, 16'h1111, 16'h2222, 16'h3333, 16'h4444, 4'b0000));
    send_tick(make_tick(16'd10, 4'b0100, '0, '0, 16'h0007, '0, 4'b0000));
    // keep bits of empty slots do nothing
    send_tick(make_tick(16'd10, 4'b0000, '0, '0, '0, '0, 4'b1110));
  endtask

  task automatic test_spare_index();
    write_reg(CFG_MODE, ms_t'(MODE_CYCLIC));
    send_tick(make_tick(16'd100, '0, '0, '0, '0, '0, '0));
    write_reg(CFG_SPARE_6, 20'hFFFFF);
    write_reg(CFG_SPARE_7, 20'h00001);
    send_tick(make_tick(16'd100, '0, '0, '0, '0, '0, '0));
  endtask

  task automatic run_random_phase(int send_gap, int recv_hold);
    logic [1:0] m;
    car_id_t    car_pool [POOL_SIZE];
    tick_word_t w;
    int         pick;
    gap_pct = send_gap;
    hold_pct = recv_hold;
    for (int b = 0; b < RANDOM_BATCHES; b++) begin
      pick = $urandom_range(9);
      if (pick < 4) m = MODE_CYCLIC;
      else if (pick < 7) m = MODE_STOP;
      else if (pick < 9) m = MODE_TJUNC;
      else m = MODE_UNDEF;
      if (m == MODE_CYCLIC || m == MODE_UNDEF) begin
        write_reg(CFG_GREEN_MS, pick_duration());
        write_reg(CFG_YELLOW_MS, pick_duration());
        write_reg(CFG_ALL_RED_MS, pick_duration());
        write_reg(CFG_START_PHASE, (ms_t'($urandom) & ~ms_t'(7)) | ms_t'($urandom_range(7)));
      end else if (m == MODE_TJUNC) begin
        write_reg(CFG_TJUNC_NS, ms_t'($urandom));
      end
      write_reg(CFG_MODE, (ms_t'($urandom) & ~ms_t'(3)) | ms_t'(m));
      if ($urandom_range(7) == 0) write_reg($urandom_range(1) ? CFG_SPARE_6 : CFG_SPARE_7,
                                            ms_t'($urandom));
      // a small pool of ids makes repeat arrivals common
      for (int i = 0; i < POOL_SIZE; i++) car_pool[i] = car_id_t'($urandom);
      for (int k = 0; k < BATCH_ITEMS; k++) begin
        case ($urandom_range(19))
          0:       w.tick_ms = 16'hFFFF;
          1:       w.tick_ms = 16'd0;
          2:       w.tick_ms = 16'($urandom);
          default: w.tick_ms = 16'($urandom_range(200));
        endcase
        w.arrival = 4'($urandom);
        if ($urandom_range(9) != 0) begin
          for (int d = 0; d < NUM_DIRS; d++) begin
            w.front_car[d] = car_pool[$urandom_range(POOL_SIZE - 1)];
            w.keep[d] = ($urandom_range(9) < 7);
          end
        end else begin
          for (int d = 0; d < NUM_DIRS; d++) w.front_car[d] = car_id_t'($urandom);
          w.keep = 4'($urandom);
        end
        send_tick(w);
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    drive_word = '0;
    out_stall = 1'b0;
    ctl_mode = MODE_CYCLIC;
    ctl_tjunc_ns = 1'b0;
    ctl_green = GREEN_MS_RST;
    ctl_yellow = YELLOW_MS_RST;
    ctl_all_red = ALL_RED_MS_RST;
    ctl_start = PH_NS_GREEN;
    reload_start();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    gap_pct = 24;
    hold_pct = 57;
    test_cyclic_defaults();
    test_duration_extremes();
    test_tjunction();
    test_stop_queue();
    test_spare_index();

    run_random_phase(24, 57);
    run_random_phase(57, 24);
    run_random_phase(0, 0);

    while (expected_words.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("sent %0d tick words, checked %0d result words, %0d register writes",
             items_sent, results_checked, cfg_writes);
    $display("covered cyclic, four-way stop and t-junction modes under three idle mixes");
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
